// ===== rtl/core/tplq_pkg.sv =====
// ----------------------------------------------------------------------------
// tplq_pkg: shared types and codes of the three-level priority FIFO unit
// Holds the operation, priority, level and status codes, the data word type
// and the control struct that travels from the queue controller to the top.
// ----------------------------------------------------------------------------
package tplq_pkg;

   localparam int NUM_LEVELS = 3;
   localparam int DATA_W     = 32;

   typedef logic [1:0]               status_type;
   typedef logic [1:0]               level_type;
   typedef logic [1:0]               priority_type;
   typedef logic signed [DATA_W-1:0] data_type;

   // Operation codes.
   localparam logic FUNC_ENQUEUE = 1'b0;
   localparam logic FUNC_DEQUEUE = 1'b1;

   // Priority codes of an enqueue; every other code selects the low queue.
   localparam priority_type PRI_HIGH = 2'd1;
   localparam priority_type PRI_MID  = 2'd2;

   // Queue levels.
   localparam level_type LEVEL_HIGH = 2'd0;
   localparam level_type LEVEL_MID  = 2'd1;
   localparam level_type LEVEL_LOW  = 2'd2;

   // Result status codes.
   localparam status_type STATUS_ENQUEUED = 2'd0;
   localparam status_type STATUS_FULL     = 2'd1;
   localparam status_type STATUS_DEQUEUED = 2'd2;
   localparam status_type STATUS_EMPTY    = 2'd3;

   // Word returned by a dequeue when every queue is empty.
   localparam data_type EMPTY_WORD = '1;

   typedef struct packed {
      status_type status;
      level_type  level;
   } info_type;

endpackage

// ===== rtl/core/tplq_mem.sv =====
// ----------------------------------------------------------------------------
// tplq_mem: entry storage of the three queues
// Single-port synchronous memory with one write or one read per cycle and a
// registered read word that holds until the next read.
// ----------------------------------------------------------------------------
module tplq_mem #(
   parameter int WORDS  = 24,
   parameter int ADDR_W = 5
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic                 re,
   input  logic [ADDR_W-1:0]    addr,
   input  tplq_pkg::data_type   wdata,
   output tplq_pkg::data_type   rdata
);
   import tplq_pkg::*;

   data_type mem [0:WORDS-1];
   data_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/tplq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tplq_ctrl: head, tail and fill count of the three queues
// Decodes an operation, picks the queue, forms the memory command and the
// result status, and updates the pointer set when the transfer is accepted.
// ----------------------------------------------------------------------------
module tplq_ctrl #(
   parameter int QUEUE_DEPTH = 8,
   parameter int PTR_W       = 3,
   parameter int CNT_W       = 4,
   parameter int ADDR_W      = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      func,
   input  tplq_pkg::priority_type    priority_req,
   output logic                      mem_we,
   output logic                      mem_re,
   output logic [ADDR_W-1:0]         mem_addr,
   output tplq_pkg::info_type        info
);
   import tplq_pkg::*;

   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [ADDR_W-1:0] BASE_MID = ADDR_W'(QUEUE_DEPTH);
   localparam logic [ADDR_W-1:0] BASE_LOW = ADDR_W'(2 * QUEUE_DEPTH);

   logic [PTR_W-1:0] head_ff [0:NUM_LEVELS-1];
   logic [PTR_W-1:0] tail_ff [0:NUM_LEVELS-1];
   logic [CNT_W-1:0] cnt_ff  [0:NUM_LEVELS-1];

   level_type        lvl;
   logic [PTR_W-1:0] ptr;
   logic [PTR_W-1:0] ptr_in;
   logic [ADDR_W-1:0] base;
   logic             do_write;
   logic             do_read;

   always_comb begin
      lvl      = LEVEL_HIGH;
      do_write = 1'b0;
      do_read  = 1'b0;
      info     = '{status: STATUS_EMPTY, level: LEVEL_HIGH};
      if (func == FUNC_ENQUEUE) begin
         unique case (priority_req)
            PRI_HIGH: lvl = LEVEL_HIGH;
            PRI_MID:  lvl = LEVEL_MID;
            default:  lvl = LEVEL_LOW;
         endcase
         info.level = lvl;
         if (cnt_ff[lvl] == CNT_FULL) begin
            info.status = STATUS_FULL;
         end else begin
            info.status = STATUS_ENQUEUED;
            do_write    = 1'b1;
         end
      end else begin
         if (cnt_ff[LEVEL_HIGH] != '0) begin
            lvl     = LEVEL_HIGH;
            do_read = 1'b1;
         end else if (cnt_ff[LEVEL_MID] != '0) begin
            lvl     = LEVEL_MID;
            do_read = 1'b1;
         end else if (cnt_ff[LEVEL_LOW] != '0) begin
            lvl     = LEVEL_LOW;
            do_read = 1'b1;
         end
         if (do_read) begin
            info.status = STATUS_DEQUEUED;
            info.level  = lvl;
         end
      end
   end

   always_comb begin
      ptr    = do_write ? tail_ff[lvl] : head_ff[lvl];
      ptr_in = (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
      unique case (lvl)
         LEVEL_MID: base = BASE_MID;
         LEVEL_LOW: base = BASE_LOW;
         default:   base = '0;
      endcase
   end

   assign mem_addr = base + ADDR_W'(ptr);
   assign mem_we   = accept && do_write;
   assign mem_re   = accept && do_read;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else if (accept) begin
         if (do_write) begin
            tail_ff[lvl] <= ptr_in;
            cnt_ff[lvl]  <= cnt_ff[lvl] + 1'b1;
         end
         if (do_read) begin
            head_ff[lvl] <= ptr_in;
            cnt_ff[lvl]  <= cnt_ff[lvl] - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/core/three_level_priority_fifo_unit.sv =====
// ----------------------------------------------------------------------------
// three_level_priority_fifo_unit: three FIFOs behind a strict-priority dequeue
// Enqueue puts a signed word into the high, middle or low queue; dequeue
// returns the oldest word of the highest queue that holds one.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Payload
//   -------  ---------  -----------------  ----------------------------------
//   req      in         req_valid/stall    func, priority_req, value
//   rsp      out        rsp_valid/stall    status, data_out, level
//
// The block sustains one transfer per cycle on each side while rsp_stall is low. The
// entry memory is read and the read stage loaded at the accepting edge; the result
// register loads from the read stage when that stage moves on, and rsp_valid rises as it loads.
// Reset clears the head, tail and fill count of every queue; the entry memory
// is not cleared, since a dequeue only reads entries already written.
// A stalled, full result register holds the read stage and raises req_stall.
//
module three_level_priority_fifo_unit #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_func,
   input  tplq_pkg::priority_type   req_priority_req,
   input  tplq_pkg::data_type       req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tplq_pkg::status_type     rsp_status,
   output tplq_pkg::data_type       rsp_data_out,
   output tplq_pkg::level_type      rsp_level
);
   import tplq_pkg::*;

   // Derived sizes: pointer within one queue, fill count that can reach the
   // depth itself, and address into the shared memory of all three queues.
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int WORDS  = NUM_LEVELS * QUEUE_DEPTH;
   localparam int ADDR_W = $clog2(WORDS);

   logic              req_accept;
   logic              mem_we;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_addr;
   data_type          mem_rdata;
   info_type          info;

   // Read stage: holds the item while the memory word is fetched.
   logic              s1_valid_ff;
   info_type          s1_info_ff;
   data_type          s1_data_ff;
   logic              s1_move;

   // Result register.
   logic              rsp_valid_ff;
   info_type          rsp_info_ff;
   data_type          rsp_data_ff;

   // The read stage moves on when the result register is empty or is being
   // emptied this cycle; a new request may then enter behind it.
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_move;
   assign req_accept = req_valid && !req_stall;

   tplq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PTR_W       (PTR_W),
      .CNT_W       (CNT_W),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .func         (req_func),
      .priority_req (req_priority_req),
      .mem_we       (mem_we),
      .mem_re       (mem_re),
      .mem_addr     (mem_addr),
      .info         (info)
   );

   // The read word stays in the memory's output register while the read
   // stage stalls, because no new read can be issued during that time.
   tplq_mem #(
      .WORDS  (WORDS),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (req_value),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Enqueues echo the input word; an all-empty dequeue returns the
   // fixed empty word.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_info_ff <= info;
         s1_data_ff <= (req_func == FUNC_ENQUEUE) ? req_value : EMPTY_WORD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_info_ff <= s1_info_ff;
         rsp_data_ff <= (s1_info_ff.status == STATUS_DEQUEUED) ? mem_rdata : s1_data_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_info_ff.status;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_level    = rsp_info_ff.level;

   // An accepted request always occupies the read stage on the next cycle.
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted request did not reach the read stage");

   // The single memory port never sees a write and a read together.
   a_one_mem_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("entry memory written and read in the same cycle");

   // An all-empty result carries the empty word and the high level.
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status == STATUS_EMPTY) |->
         (rsp_data_out == EMPTY_WORD && rsp_level == LEVEL_HIGH))
      else $error("empty result has wrong word or level");

endmodule
